// ===== hw/rtl/wuf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted union-find package
// Shared widths, defaults, command codes and the sequencer state type.
// ----------------------------------------------------------------------------
package wuf_pkg;

    localparam int ID_W         = 10;
    localparam int SIZE_W       = 11;
    localparam int SET_SIZE_DEF = 1024;

    localparam logic CMD_UNION = 1'b0;
    localparam logic CMD_FIND  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_A,
        S_WALK_B,
        S_SZA,
        S_SZB,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/wuf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted union-find RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module wuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/weighted_union_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted union-find
// Disjoint-set forest with find and union-by-size commands.
// ----------------------------------------------------------------------------
// The input channel takes one command word (cmd, first_id, second_id) when
// i_in_valid is high and o_in_stall is low. A find returns the root of
// first_id and the size of its set. A union joins the two sets, the smaller
// tree going under the larger, and returns the new root and merged size; if
// both ids already share a root nothing changes and already_joined is set.
// Parent links and tree sizes live in two synchronous RAMs, and one parent
// link is followed per cycle. A find walks the path of first_id to its root
// and then reads the root's size; a union walks both paths and, for
// distinct roots, reads both sizes and writes the new link and merged size.
// Weighted trees keep each path within log2 of SET_SIZE links. After reset
// the block sweeps both RAMs, one entry per cycle, while o_in_stall stays
// high. Results sit in an output register; a stalled receiver holds the
// word there, and the block accepts the next command meanwhile but holds
// its own result until the register frees.
// ----------------------------------------------------------------------------
module weighted_union_find #(
    parameter int SET_SIZE = wuf_pkg::SET_SIZE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_cmd,
    input  logic [wuf_pkg::ID_W-1:0]  i_first_id,
    input  logic [wuf_pkg::ID_W-1:0]  i_second_id,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [wuf_pkg::ID_W-1:0]  o_root,
    output logic [wuf_pkg::SIZE_W-1:0] o_root_set_size,
    output logic                      o_already_joined
);

    import wuf_pkg::*;

    localparam int AW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
    localparam logic [16:0] LastId = 17'(SET_SIZE - 1);

    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_idx, n_clr_idx;
    logic              r_cmd, n_cmd;
    logic [AW-1:0]     r_b, n_b;
    logic [AW-1:0]     r_cur, n_cur;
    logic [AW-1:0]     r_ra, n_ra;
    logic [AW-1:0]     r_rb, n_rb;
    logic [SIZE_W-1:0] r_sza, n_sza;
    logic [AW-1:0]     r_top, n_top;
    logic [SIZE_W-1:0] r_size, n_size;
    logic              r_joined, n_joined;
    logic              r_out_valid, n_out_valid;
    logic [ID_W-1:0]   r_out_root;
    logic [SIZE_W-1:0] r_out_size;
    logic              r_out_joined;
    logic              out_load;

    logic [16:0]       ext_a, ext_b;
    logic [AW-1:0]     id_a, id_b;
    logic [SIZE_W-1:0] w_sum;

    logic              p_we, s_we;
    logic [AW-1:0]     p_waddr, p_wdata, p_raddr, p_rdata;
    logic [AW-1:0]     s_waddr, s_raddr;
    logic [SIZE_W-1:0] s_wdata, s_rdata;

    wuf_ram #(
        .WIDTH (AW),
        .DEPTH (SET_SIZE)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    wuf_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (SET_SIZE)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // Ids beyond the forest fold onto its last element.
    always_comb begin
        ext_a = 17'(i_first_id);
        ext_b = 17'(i_second_id);
        if (ext_a > LastId) begin
            ext_a = LastId;
        end
        if (ext_b > LastId) begin
            ext_b = LastId;
        end
        id_a = ext_a[AW-1:0];
        id_b = ext_b[AW-1:0];
    end

    assign w_sum = r_sza + s_rdata;

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_cmd     = r_cmd;
        n_b       = r_b;
        n_cur     = r_cur;
        n_ra      = r_ra;
        n_rb      = r_rb;
        n_sza     = r_sza;
        n_top     = r_top;
        n_size    = r_size;
        n_joined  = r_joined;
        out_load  = 1'b0;
        p_we      = 1'b0;
        p_waddr   = r_clr_idx;
        p_wdata   = r_clr_idx;
        p_raddr   = r_cur;
        s_we      = 1'b0;
        s_waddr   = r_clr_idx;
        s_wdata   = SIZE_W'(1);
        s_raddr   = r_ra;
        case (r_state)
            S_CLEAR: begin
                p_we      = 1'b1;
                s_we      = 1'b1;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == AW'(SET_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                p_raddr = id_a;
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_cur   = id_a;
                    n_b     = id_b;
                    n_state = S_WALK_A;
                end
            end
            S_WALK_A: begin
                if (p_rdata == r_cur) begin
                    n_ra = r_cur;
                    if (r_cmd == CMD_FIND) begin
                        s_raddr = r_cur;
                        n_state = S_SZA;
                    end else begin
                        n_cur   = r_b;
                        p_raddr = r_b;
                        n_state = S_WALK_B;
                    end
                end else begin
                    n_cur   = p_rdata;
                    p_raddr = p_rdata;
                end
            end
            S_WALK_B: begin
                if (p_rdata == r_cur) begin
                    n_rb    = r_cur;
                    s_raddr = r_ra;
                    n_state = S_SZA;
                end else begin
                    n_cur   = p_rdata;
                    p_raddr = p_rdata;
                end
            end
            S_SZA: begin
                n_sza = s_rdata;
                if (r_cmd == CMD_FIND || r_ra == r_rb) begin
                    n_top    = r_ra;
                    n_size   = s_rdata;
                    n_joined = (r_cmd == CMD_UNION);
                    n_state  = S_DONE;
                end else begin
                    s_raddr = r_rb;
                    n_state = S_SZB;
                end
            end
            S_SZB: begin
                p_we     = 1'b1;
                s_we     = 1'b1;
                s_wdata  = w_sum;
                n_size   = w_sum;
                n_joined = 1'b0;
                if (s_rdata < r_sza) begin
                    p_waddr = r_rb;
                    p_wdata = r_ra;
                    s_waddr = r_ra;
                    n_top   = r_ra;
                end else begin
                    p_waddr = r_ra;
                    p_wdata = r_rb;
                    s_waddr = r_rb;
                    n_top   = r_rb;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = out_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_b      <= n_b;
        r_cur    <= n_cur;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_sza    <= n_sza;
        r_top    <= n_top;
        r_size   <= n_size;
        r_joined <= n_joined;
        if (out_load) begin
            r_out_root   <= ID_W'(r_top);
            r_out_size   <= r_size;
            r_out_joined <= r_joined;
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_root           = r_out_root;
    assign o_root_set_size  = r_out_size;
    assign o_already_joined = r_out_joined;

`ifndef NO_ASSERTIONS
    // A merge never links a root to itself.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SZB) |-> (r_ra != r_rb))
        else $error("merge of a root with itself");

    // The merged size exceeds the size of either tree.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SZB) |-> (w_sum > r_sza && w_sum > s_rdata))
        else $error("merged size did not grow");

    // A finished result reaches the output register once it is free.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || !i_out_stall)) |=>
            (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into the output register");

    // No result appears while the memories are being cleared.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("output word during memory clear");
`endif

endmodule

// ===== verif/tb_weighted_union_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted union-find testbench
// Drives find and union words into weighted_union_find and checks every
// result word against a behavioral disjoint-set forest or a scripted answer.
// A short directed table covers the fresh forest, ties, repeated unions and
// the id extremes. A randomized part then merges neighboring blocks level by
// level until one set of 1024 remains, which builds the deepest trees, mixed
// with finds and stray unions. Both sides idle and stall at random, and the
// receiver once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_weighted_union_find;

    import wuf_pkg::*;

    localparam int FOREST      = SET_SIZE_DEF;
    localparam int LIMIT       = 400000;
    localparam int DRAIN       = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 1000;

    typedef struct packed {
        logic [ID_W-1:0]   root;
        logic [SIZE_W-1:0] size;
        logic              joined;
    } t_answer;

    typedef struct {
        logic            cmd;
        logic [ID_W-1:0] first;
        logic [ID_W-1:0] second;
        bit              typed;
        t_answer         want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic                i_cmd = CMD_UNION;
    logic [ID_W-1:0]     i_first_id = '0;
    logic [ID_W-1:0]     i_second_id = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [ID_W-1:0]     o_root;
    logic [SIZE_W-1:0]   o_root_set_size;
    logic                o_already_joined;

    logic [ID_W-1:0]     parent_link [FOREST];
    logic [SIZE_W-1:0]   member_count [FOREST];
    t_answer             pending_answers [$];
    int                  mismatch_count = 0;
    int                  words_accepted = 0;
    int                  cycle_count = 0;
    int                  send_idle_pct = 10;
    int                  recv_idle_pct = 73;
    int                  hold_left = 0;
    bit                  hold_done = 1'b0;
    t_row                script [13];

    weighted_union_find dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_first_id       (i_first_id),
        .i_second_id      (i_second_id),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_root           (o_root),
        .o_root_set_size  (o_root_set_size),
        .o_already_joined (o_already_joined)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [ID_W-1:0] find_root(input logic [ID_W-1:0] node);
        logic [ID_W-1:0] cur;
        int              steps;
        cur = node;
        steps = 0;
        while (steps < FOREST && parent_link[cur] != cur) begin
            cur = parent_link[cur];
            steps++;
        end
        return cur;
    endfunction

    function automatic t_answer resolve_command(input logic cmd,
                                                input logic [ID_W-1:0] a,
                                                input logic [ID_W-1:0] b);
        t_answer         ans;
        logic [ID_W-1:0] ra;
        logic [ID_W-1:0] rb;
        ra = find_root(a);
        ans.joined = 1'b0;
        if (cmd == CMD_FIND) begin
            ans.root = ra;
        end else begin
            rb = find_root(b);
            if (ra == rb) begin
                ans.root = ra;
                ans.joined = 1'b1;
            end else if (member_count[rb] < member_count[ra]) begin
                parent_link[rb] = ra;
                member_count[ra] = member_count[ra] + member_count[rb];
                ans.root = ra;
            end else begin
                parent_link[ra] = rb;
                member_count[rb] = member_count[rb] + member_count[ra];
                ans.root = rb;
            end
        end
        ans.size = member_count[ans.root];
        return ans;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_word(input logic cmd, input logic [ID_W-1:0] a,
                             input logic [ID_W-1:0] b, input bit typed,
                             input t_answer want);
        t_answer got;
        if (words_accepted < 440) begin
            send_idle_pct = 10;
            recv_idle_pct = 73;
        end else if (words_accepted < 880) begin
            send_idle_pct = 73;
            recv_idle_pct = 10;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_first_id  <= a;
        i_second_id <= b;
        do @(posedge i_clk); while (o_in_stall);
        got = resolve_command(cmd, a, b);
        pending_answers.insert(pending_answers.size(), typed ? want : got);
        words_accepted++;
    endtask

    // Receiver stall, with one long hold-off once the run is under way.
    always @(posedge i_clk) begin
        if (!hold_done && words_accepted >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_answer exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected word root=%0d size=%0d joined=%0d",
                                          o_root, o_root_set_size, o_already_joined));
            end else begin
                exp = pending_answers.pop_front();
                if (o_root !== exp.root)
                    report_mismatch($sformatf("root got %0d want %0d", o_root, exp.root));
                if (o_root_set_size !== exp.size)
                    report_mismatch($sformatf("root_set_size got %0d want %0d",
                                              o_root_set_size, exp.size));
                if (o_already_joined !== exp.joined)
                    report_mismatch($sformatf("already_joined got %0d want %0d",
                                              o_already_joined, exp.joined));
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("weighted_union_find test failed");
        $finish;
    end

    initial begin
        int      order [$];
        int      stride;
        int      base;
        int      j;
        int      tmp;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
        t_answer none;

        none = '0;
        for (int i = 0; i < FOREST; i++) begin
            parent_link[i]  = ID_W'(i);
            member_count[i] = SIZE_W'(1);
        end

        // Fresh forest, ties, repeated unions and id extremes.
        script[0]  = '{CMD_FIND,  10'd0,    10'd0,    1'b1, '{10'd0,    11'd1, 1'b0}};
        script[1]  = '{CMD_FIND,  10'd1023, 10'd682,  1'b1, '{10'd1023, 11'd1, 1'b0}};
        script[2]  = '{CMD_UNION, 10'd0,    10'd1023, 1'b1, '{10'd1023, 11'd2, 1'b0}};
        script[3]  = '{CMD_UNION, 10'd1023, 10'd0,    1'b1, '{10'd1023, 11'd2, 1'b1}};
        script[4]  = '{CMD_UNION, 10'd341,  10'd341,  1'b1, '{10'd341,  11'd1, 1'b1}};
        script[5]  = '{CMD_FIND,  10'd0,    10'd1023, 1'b1, '{10'd1023, 11'd2, 1'b0}};
        script[6]  = '{CMD_UNION, 10'd1,    10'd0,    1'b0, none};
        script[7]  = '{CMD_UNION, 10'd1023, 10'd2,    1'b0, none};
        script[8]  = '{CMD_UNION, 10'd3,    10'd4,    1'b1, '{10'd4,    11'd2, 1'b0}};
        script[9]  = '{CMD_UNION, 10'd3,    10'd1,    1'b0, none};
        script[10] = '{CMD_FIND,  10'd3,    10'd0,    1'b0, none};
        script[11] = '{CMD_UNION, 10'd682,  10'd341,  1'b1, '{10'd341,  11'd2, 1'b0}};
        script[12] = '{CMD_FIND,  10'd682,  10'd1023, 1'b0, none};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i])
            send_word(script[i].cmd, script[i].first, script[i].second,
                      script[i].typed, script[i].want);

        // Join neighboring blocks level by level until a single set remains.
        for (stride = 1; stride < FOREST; stride = stride * 2) begin
            order.delete();
            for (int k = 0; k < FOREST / (2 * stride); k++)
                order.insert(order.size(), k);
            for (int i = order.size() - 1; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            foreach (order[i]) begin
                base = order[i] * 2 * stride;
                a = ID_W'(base + $urandom_range(stride - 1));
                b = ID_W'(base + stride + $urandom_range(stride - 1));
                if ($urandom_range(1))
                    send_word(CMD_UNION, b, a, 1'b0, none);
                else
                    send_word(CMD_UNION, a, b, 1'b0, none);
                if ($urandom_range(99) < 25)
                    send_word(CMD_FIND, ID_W'($urandom_range(FOREST - 1)),
                              ID_W'($urandom_range(FOREST - 1)), 1'b0, none);
                if ($urandom_range(99) < 3)
                    send_word(CMD_UNION, ID_W'($urandom_range(FOREST - 1)),
                              ID_W'($urandom_range(FOREST - 1)), 1'b0, none);
            end
        end

        repeat (16)
            send_word(logic'($urandom_range(1)), ID_W'($urandom_range(FOREST - 1)),
                      ID_W'($urandom_range(FOREST - 1)), 1'b0, none);

        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("weighted_union_find test passed");
        end else begin
            $display("weighted_union_find test failed");
        end
        $finish;
    end

endmodule
